// File: design/dsfpa_pkg.sv
// shared types, constants and helpers for the dust sensor frame parser and averager
// no dependencies; imported by the parser, averager and top modules

package dsfpa_pkg;

    localparam int AVG_COUNT_DEF = 8;
    localparam int MAX_FRAME_DEF = 32;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int POS_W     = 6;
    localparam int SUM_W     = 22;
    localparam int CLASS_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h42;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h4D;

    localparam int FRAME_OVERHEAD = 4;
    localparam int POS_LEN_END    = 4;
    localparam int POS_FINE_END   = 8;
    localparam int POS_COARSE_END = 10;

    localparam logic [WORD_W-1:0] FINE_GOOD_RST     = 16'd15;
    localparam logic [WORD_W-1:0] FINE_NORMAL_RST   = 16'd35;
    localparam logic [WORD_W-1:0] FINE_BAD_RST      = 16'd75;
    localparam logic [WORD_W-1:0] COARSE_GOOD_RST   = 16'd30;
    localparam logic [WORD_W-1:0] COARSE_NORMAL_RST = 16'd80;
    localparam logic [WORD_W-1:0] COARSE_BAD_RST    = 16'd150;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FINE_GOOD,
        CFG_FINE_NORMAL,
        CFG_FINE_BAD,
        CFG_COARSE_GOOD,
        CFG_COARSE_NORMAL,
        CFG_COARSE_BAD
    } cfg_idx_t;

    typedef enum logic [CLASS_W-1:0] {
        AQ_GOOD,
        AQ_NORMAL,
        AQ_BAD,
        AQ_VERY_BAD
    } aq_class_t;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
    } cfg_wr_t;

    typedef struct packed {
        logic [WORD_W-1:0] fine_good;
        logic [WORD_W-1:0] fine_normal;
        logic [WORD_W-1:0] fine_bad;
        logic [WORD_W-1:0] coarse_good;
        logic [WORD_W-1:0] coarse_normal;
        logic [WORD_W-1:0] coarse_bad;
    } limits_t;

    typedef struct packed {
        logic              good;
        logic [WORD_W-1:0] fine;
        logic [WORD_W-1:0] coarse;
    } frame_evt_t;

    typedef struct packed {
        logic              good;
        logic [WORD_W-1:0] fine;
        logic [WORD_W-1:0] coarse;
        logic              avg_ready;
        logic [WORD_W-1:0] avg_fine;
        logic [WORD_W-1:0] avg_coarse;
        aq_class_t         fine_class;
        aq_class_t         coarse_class;
    } result_t;

    function automatic aq_class_t classify(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] lim_good,
        input logic [WORD_W-1:0] lim_normal,
        input logic [WORD_W-1:0] lim_bad
    );
        aq_class_t c;
        if (v <= lim_good)
        begin
            c = AQ_GOOD;
        end
        else if (v <= lim_normal)
        begin
            c = AQ_NORMAL;
        end
        else if (v <= lim_bad)
        begin
            c = AQ_BAD;
        end
        else
        begin
            c = AQ_VERY_BAD;
        end
        return c;
    endfunction

endpackage

// File: design/dsfpa_fifo.sv
// small first-in first-out queue of generic items
// depends on nothing; used between parser and averager and at the result side

module dsfpa_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  item_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output item_t rd_data,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: design/dsfpa_parser.sv
// front part: byte-wise header hunt, length check, checksum and word capture
// depends on dsfpa_pkg; emits one frame request per finished or rejected frame

module dsfpa_parser
    import dsfpa_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              evt_valid,
    output frame_evt_t        evt
);

    logic                in_body_reg, in_body_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    total_reg, total_next;
    logic [WORD_W-1:0]   sum_reg, sum_next;
    logic [BYTE_W-1:0]   prev_reg, prev_next;
    logic [WORD_W-1:0]   fine_reg, fine_next;
    logic [WORD_W-1:0]   coarse_reg, coarse_next;

    logic [WORD_W-1:0]   word;
    logic [POS_W-1:0]    pos_inc;
    logic [POS_W-1:0]    total_fresh;
    logic [POS_W-1:0]    total_eff;
    logic                len_over;
    logic                end_hit;

    assign word        = {prev_reg, rx_byte};
    assign pos_inc     = pos_reg + 1'b1;
    assign total_fresh = word[POS_W-1:0] + POS_W'(FRAME_OVERHEAD);
    assign len_over    = (pos_inc == POS_W'(POS_LEN_END))
                         && (word > WORD_W'(MAX_FRAME - FRAME_OVERHEAD));
    assign total_eff   = (pos_inc == POS_W'(POS_LEN_END)) ? total_fresh : total_reg;
    assign end_hit     = (pos_inc >= POS_W'(POS_LEN_END)) && (pos_inc >= total_eff);

    always_comb
    begin
        in_body_next = in_body_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        sum_next     = sum_reg;
        prev_next    = prev_reg;
        fine_next    = fine_reg;
        coarse_next  = coarse_reg;
        evt_valid    = 1'b0;
        evt          = '0;
        if (in_valid)
        begin
            prev_next = rx_byte;
            if (!in_body_reg)
            begin
                if (rx_byte == HDR_FIRST && (pos_reg == POS_W'(0) || pos_reg == POS_W'(1)))
                begin
                    pos_next    = POS_W'(1);
                    sum_next    = WORD_W'(HDR_FIRST);
                    fine_next   = '0;
                    coarse_next = '0;
                end
                else if (rx_byte == HDR_SECOND && pos_reg == POS_W'(1))
                begin
                    pos_next     = POS_W'(2);
                    sum_next     = sum_reg + WORD_W'(HDR_SECOND);
                    in_body_next = 1'b1;
                end
                else
                begin
                    pos_next = '0;
                end
            end
            else
            begin
                sum_next = sum_reg + WORD_W'(rx_byte);
                pos_next = pos_inc;
                if (pos_inc == POS_W'(POS_LEN_END) && !len_over)
                begin
                    total_next = total_fresh;
                end
                if (pos_inc == POS_W'(POS_FINE_END))
                begin
                    fine_next = word;
                end
                if (pos_inc == POS_W'(POS_COARSE_END))
                begin
                    coarse_next = word;
                end
                if (len_over)
                begin
                    evt_valid    = 1'b1;
                    evt.good     = 1'b0;
                    evt.fine     = fine_reg;
                    evt.coarse   = coarse_reg;
                    in_body_next = 1'b0;
                    pos_next     = '0;
                end
                else if (end_hit)
                begin
                    // checksum covers every byte before the trailing two
                    evt_valid    = 1'b1;
                    evt.good     = ((sum_reg - WORD_W'(prev_reg)) == word);
                    evt.fine     = fine_next;
                    evt.coarse   = coarse_next;
                    in_body_next = 1'b0;
                    pos_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg <= 1'b0;
            pos_reg     <= '0;
            total_reg   <= '0;
            sum_reg     <= '0;
            prev_reg    <= '0;
            fine_reg    <= '0;
            coarse_reg  <= '0;
        end
        else
        begin
            in_body_reg <= in_body_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            sum_reg     <= sum_next;
            prev_reg    <= prev_next;
            fine_reg    <= fine_next;
            coarse_reg  <= coarse_next;
        end
    end

endmodule

// File: design/dsfpa_averager.sv
// back part: batch accumulation, constant division by reciprocal and classing
// depends on dsfpa_pkg; holds the limit registers written through the config port

module dsfpa_averager
    import dsfpa_pkg::*;
#(
    parameter int AVG_COUNT = AVG_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_wr_t    cfg,
    input  logic       evt_empty,
    output logic       evt_pop,
    input  frame_evt_t evt,
    input  logic       res_full,
    output logic       res_push,
    output result_t    res
);

    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int CNT_W   = $clog2(AVG_COUNT + 1);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((longint'(1) << SUM_W) / AVG_COUNT);
    localparam logic [SUM_W-1:0]   AVG_N = SUM_W'(AVG_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_CLASS
    } state_t;

    state_t              state_reg, state_next;
    limits_t             limits_reg, limits_next;
    logic [SUM_W-1:0]    sum_f_reg, sum_f_next;
    logic [SUM_W-1:0]    sum_c_reg, sum_c_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    div_f_reg, div_f_next;
    logic [SUM_W-1:0]    div_c_reg, div_c_next;
    logic [WORD_W-1:0]   avg_f_reg, avg_f_next;
    logic [WORD_W-1:0]   avg_c_reg, avg_c_next;
    logic [WORD_W-1:0]   frm_f_reg, frm_f_next;
    logic [WORD_W-1:0]   frm_c_reg, frm_c_next;

    logic [SUM_W-1:0]    sum_f_add, sum_c_add;
    logic [CNT_W-1:0]    cnt_add;
    logic [PROD_W-1:0]   prod_f, prod_c;
    logic [SUM_W-1:0]    rem_f, rem_c;

    assign sum_f_add = sum_f_reg + SUM_W'(evt.fine);
    assign sum_c_add = sum_c_reg + SUM_W'(evt.coarse);
    assign cnt_add   = cnt_reg + 1'b1;
    assign prod_f    = PROD_W'(div_f_reg) * PROD_W'(RECIP);
    assign prod_c    = PROD_W'(div_c_reg) * PROD_W'(RECIP);
    assign rem_f     = div_f_reg - SUM_W'(avg_f_reg) * AVG_N;
    assign rem_c     = div_c_reg - SUM_W'(avg_c_reg) * AVG_N;

    always_comb
    begin
        state_next  = state_reg;
        limits_next = limits_reg;
        sum_f_next  = sum_f_reg;
        sum_c_next  = sum_c_reg;
        cnt_next    = cnt_reg;
        div_f_next  = div_f_reg;
        div_c_next  = div_c_reg;
        avg_f_next  = avg_f_reg;
        avg_c_next  = avg_c_reg;
        frm_f_next  = frm_f_reg;
        frm_c_next  = frm_c_reg;
        evt_pop     = 1'b0;
        res_push    = 1'b0;
        res         = '0;

        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_FINE_GOOD:     limits_next.fine_good     = cfg.data;
                CFG_FINE_NORMAL:   limits_next.fine_normal   = cfg.data;
                CFG_FINE_BAD:      limits_next.fine_bad      = cfg.data;
                CFG_COARSE_GOOD:   limits_next.coarse_good   = cfg.data;
                CFG_COARSE_NORMAL: limits_next.coarse_normal = cfg.data;
                CFG_COARSE_BAD:    limits_next.coarse_bad    = cfg.data;
                default:           limits_next = limits_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!evt_empty && !res_full)
                begin
                    evt_pop = 1'b1;
                    if (!evt.good)
                    begin
                        res_push   = 1'b1;
                        res.fine   = evt.fine;
                        res.coarse = evt.coarse;
                    end
                    else if (cnt_add == CNT_W'(AVG_COUNT))
                    begin
                        div_f_next = sum_f_add;
                        div_c_next = sum_c_add;
                        frm_f_next = evt.fine;
                        frm_c_next = evt.coarse;
                        sum_f_next = '0;
                        sum_c_next = '0;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        sum_f_next = sum_f_add;
                        sum_c_next = sum_c_add;
                        cnt_next   = cnt_add;
                        res_push   = 1'b1;
                        res.good   = 1'b1;
                        res.fine   = evt.fine;
                        res.coarse = evt.coarse;
                    end
                end
            end
            ST_MUL:
            begin
                // quotient estimate, low by at most one
                avg_f_next = prod_f[SUM_W +: WORD_W];
                avg_c_next = prod_c[SUM_W +: WORD_W];
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (rem_f >= AVG_N)
                begin
                    avg_f_next = avg_f_reg + 1'b1;
                end
                if (rem_c >= AVG_N)
                begin
                    avg_c_next = avg_c_reg + 1'b1;
                end
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                if (!res_full)
                begin
                    res_push         = 1'b1;
                    res.good         = 1'b1;
                    res.fine         = frm_f_reg;
                    res.coarse       = frm_c_reg;
                    res.avg_ready    = 1'b1;
                    res.avg_fine     = avg_f_reg;
                    res.avg_coarse   = avg_c_reg;
                    res.fine_class   = classify(avg_f_reg, limits_reg.fine_good,
                                                limits_reg.fine_normal, limits_reg.fine_bad);
                    res.coarse_class = classify(avg_c_reg, limits_reg.coarse_good,
                                                limits_reg.coarse_normal,
                                                limits_reg.coarse_bad);
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                <= ST_IDLE;
            limits_reg.fine_good     <= FINE_GOOD_RST;
            limits_reg.fine_normal   <= FINE_NORMAL_RST;
            limits_reg.fine_bad      <= FINE_BAD_RST;
            limits_reg.coarse_good   <= COARSE_GOOD_RST;
            limits_reg.coarse_normal <= COARSE_NORMAL_RST;
            limits_reg.coarse_bad    <= COARSE_BAD_RST;
            sum_f_reg                <= '0;
            sum_c_reg                <= '0;
            cnt_reg                  <= '0;
            div_f_reg                <= '0;
            div_c_reg                <= '0;
            avg_f_reg                <= '0;
            avg_c_reg                <= '0;
            frm_f_reg                <= '0;
            frm_c_reg                <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            limits_reg <= limits_next;
            sum_f_reg  <= sum_f_next;
            sum_c_reg  <= sum_c_next;
            cnt_reg    <= cnt_next;
            div_f_reg  <= div_f_next;
            div_c_reg  <= div_c_next;
            avg_f_reg  <= avg_f_next;
            avg_c_reg  <= avg_c_next;
            frm_f_reg  <= frm_f_next;
            frm_c_reg  <= frm_c_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_below_batch: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(AVG_COUNT))
        else $error("good frame count reached batch size without flush");

    a_sums_clear_on_empty_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (sum_f_reg == '0 && sum_c_reg == '0))
        else $error("batch sums not cleared with count");

    a_estimate_within_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> (rem_f < (AVG_N << 1) && rem_c < (AVG_N << 1)))
        else $error("reciprocal quotient off by more than one");

    a_average_only_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.avg_ready) |-> (res.good && state_reg == ST_CLASS))
        else $error("average request without a good frame");
`endif

endmodule

// File: design/dust_sensor_frame_parser_averager.sv
// path: a frame request goes from the frame queue through the averager into the result queue;
// one that closes an averaging batch first runs through the multiply, correct and class states
// throughput: one byte per cycle while full is low; full rises only when the four-entry frame queue backs up
// reset: asynchronous active-low; parser hunts for a header, batch is empty, limits at defaults
// depends on dsfpa_pkg, dsfpa_fifo, dsfpa_parser, dsfpa_averager

module dust_sensor_frame_parser_averager
    import dsfpa_pkg::*;
#(
    parameter int AVG_COUNT = AVG_COUNT_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic                 frame_good,
    output logic [WORD_W-1:0]    frame_fine,
    output logic [WORD_W-1:0]    frame_coarse,
    output logic                 average_ready,
    output logic [WORD_W-1:0]    average_fine,
    output logic [WORD_W-1:0]    average_coarse,
    output logic [CLASS_W-1:0]   fine_class,
    output logic [CLASS_W-1:0]   coarse_class,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic       byte_take;
    logic       evt_valid;
    frame_evt_t evt_in;
    frame_evt_t evt_out;
    logic       evt_empty;
    logic       evt_pop;
    logic       res_push;
    logic       res_full;
    result_t    res_in;
    result_t    res_out;
    cfg_wr_t    cfg;

    assign byte_take = push && !full;
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    dsfpa_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_take),
        .rx_byte   (rx_byte),
        .evt_valid (evt_valid),
        .evt       (evt_in)
    );

    dsfpa_fifo #(
        .item_t (frame_evt_t),
        .DEPTH  (MID_DEPTH)
    ) u_evt_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (evt_valid),
        .wr_data (evt_in),
        .full    (full),
        .rd_en   (evt_pop),
        .rd_data (evt_out),
        .empty   (evt_empty)
    );

    dsfpa_averager #(
        .AVG_COUNT (AVG_COUNT)
    ) u_averager (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .evt_empty (evt_empty),
        .evt_pop   (evt_pop),
        .evt       (evt_out),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    dsfpa_fifo #(
        .item_t (result_t),
        .DEPTH  (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign frame_good     = res_out.good;
    assign frame_fine     = res_out.fine;
    assign frame_coarse   = res_out.coarse;
    assign average_ready  = res_out.avg_ready;
    assign average_fine   = res_out.avg_fine;
    assign average_coarse = res_out.avg_coarse;
    assign fine_class     = res_out.fine_class;
    assign coarse_class   = res_out.coarse_class;

endmodule
